### sv/lcm_pkg.sv
// ----------------------------------------------------------------------------
// lcm_pkg
// Shared types and codes for the linked chain manager.
// ----------------------------------------------------------------------------
package lcm_pkg;

    // field widths of the command and result items
    localparam int ENTRY_W = 6;
    localparam int OP_W    = 2;

    typedef logic [OP_W-1:0]    op_t;
    typedef logic [ENTRY_W-1:0] entry_t;

    // operation codes
    localparam op_t OP_CONNECT    = 2'd0;
    localparam op_t OP_DISCONNECT = 2'd1;
    localparam op_t OP_QUERY      = 2'd2;

    // write command toward one link table
    typedef struct packed {
        logic set;   // store a link and mark it present
        logic clr;   // mark the link absent
    } link_cmd_t;

endpackage

### sv/lcm_cmd_if.sv
// ----------------------------------------------------------------------------
// lcm_cmd_if
// Command channel: valid/ready handshake carrying one command item.
// ----------------------------------------------------------------------------
interface lcm_cmd_if;
    import lcm_pkg::*;

    logic   valid;
    logic   ready;
    op_t    op;
    entry_t front_entry;
    entry_t back_entry;

    modport source (output valid, output op, output front_entry, output back_entry,
                    input ready);
    modport sink   (input valid, input op, input front_entry, input back_entry,
                    output ready);
endinterface

### sv/lcm_res_if.sv
// ----------------------------------------------------------------------------
// lcm_res_if
// Result channel: valid/ready handshake carrying one chain entry item.
// ----------------------------------------------------------------------------
interface lcm_res_if;
    import lcm_pkg::*;

    logic   valid;
    logic   ready;
    entry_t entry_id;
    entry_t chain_position;
    logic   last;

    modport source (output valid, output entry_id, output chain_position, output last,
                    input ready);
    modport sink   (input valid, input entry_id, input chain_position, input last,
                    output ready);
endinterface

### sv/lcm_link_ram.sv
// ----------------------------------------------------------------------------
// lcm_link_ram
// One link table: synchronous memory with a registered read plus a
// presence bit per entry that reset clears.
// ----------------------------------------------------------------------------
module lcm_link_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                clk,
    input  logic                rst_n,
    input  lcm_pkg::link_cmd_t  cmd,
    input  logic [AW-1:0]       wr_addr,
    input  logic [AW-1:0]       wr_data,
    input  logic [AW-1:0]       rd_addr,
    output logic [AW-1:0]       rd_data,
    output logic                rd_present
);
    import lcm_pkg::*;

    logic [AW-1:0]    mem [DEPTH];
    logic [DEPTH-1:0] present_reg;
    logic [AW-1:0]    rd_data_reg;
    logic             rd_present_reg;

    // link storage and registered read
    always_ff @(posedge clk)
    begin
        if (cmd.set)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // presence bits, cleared to no link at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_reg    <= '0;
            rd_present_reg <= 1'b0;
        end
        else
        begin
            if (cmd.set)
            begin
                present_reg[wr_addr] <= 1'b1;
            end
            else if (cmd.clr)
            begin
                present_reg[wr_addr] <= 1'b0;
            end
            rd_present_reg <= present_reg[rd_addr];
        end
    end

    assign rd_data    = rd_data_reg;
    assign rd_present = rd_present_reg;

endmodule

### sv/lcm_walker.sv
// ----------------------------------------------------------------------------
// lcm_walker
// Command decode, table write control and the back/forward chain walk with
// its result register.
// ----------------------------------------------------------------------------
module lcm_walker #(
    parameter int NUM_ENTRIES = 64,
    parameter int AW          = 6
) (
    input  logic               clk,
    input  logic               rst_n,
    lcm_cmd_if.sink            cmd,
    lcm_res_if.source          res,
    output lcm_pkg::link_cmd_t pred_cmd,
    output lcm_pkg::link_cmd_t succ_cmd,
    output logic [AW-1:0]      pred_wr_addr,
    output logic [AW-1:0]      pred_wr_data,
    output logic [AW-1:0]      succ_wr_addr,
    output logic [AW-1:0]      succ_wr_data,
    output logic [AW-1:0]      rd_addr,
    input  logic [AW-1:0]      pred_rd_data,
    input  logic               pred_rd_present,
    input  logic [AW-1:0]      succ_rd_data,
    input  logic               succ_rd_present
);
    import lcm_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_BACK = 2'd1;
    localparam logic [1:0] S_FWD  = 2'd2;

    localparam logic [ENTRY_W:0] ENTRY_LIM = (ENTRY_W+1)'(NUM_ENTRIES);
    localparam logic [AW:0]      STEP_MAX  = (AW+1)'(NUM_ENTRIES - 1);
    localparam logic [AW-1:0]    POS_MAX   = AW'(NUM_ENTRIES - 1);

    logic [1:0]    state_reg, state_next;
    logic [AW-1:0] cur_reg, cur_next;
    logic [AW:0]   steps_reg, steps_next;
    logic [AW-1:0] pos_reg, pos_next;

    logic          out_valid_reg, out_valid_next;
    logic [AW-1:0] out_entry_reg, out_entry_next;
    logic [AW-1:0] out_pos_reg, out_pos_next;
    logic          out_last_reg, out_last_next;

    logic accept;
    logic in_range;
    logic out_free;
    logic tail;

    // command decode
    assign accept   = cmd.valid && cmd.ready;
    assign in_range = ({1'b0, cmd.front_entry} < ENTRY_LIM)
                   && ({1'b0, cmd.back_entry} < ENTRY_LIM);
    assign cmd.ready = (state_reg == S_IDLE);

    // table writes for connect and disconnect
    always_comb
    begin
        pred_cmd = '0;
        succ_cmd = '0;
        if (accept && in_range)
        begin
            unique case (cmd.op)
                OP_CONNECT:
                begin
                    pred_cmd.set = 1'b1;
                    succ_cmd.set = 1'b1;
                end
                OP_DISCONNECT:
                begin
                    pred_cmd.clr = 1'b1;
                    succ_cmd.clr = 1'b1;
                end
                default:
                begin
                    pred_cmd = '0;
                    succ_cmd = '0;
                end
            endcase
        end
    end

    assign succ_wr_addr = cmd.front_entry[AW-1:0];
    assign succ_wr_data = cmd.back_entry[AW-1:0];
    assign pred_wr_addr = cmd.back_entry[AW-1:0];
    assign pred_wr_data = cmd.front_entry[AW-1:0];

    // result register is free when empty or being taken
    assign out_free = !out_valid_reg || res.ready;
    assign tail     = !succ_rd_present || (pos_reg == POS_MAX);

    // walk sequencer; memory read address always follows the current entry
    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        steps_next     = steps_reg;
        pos_next       = pos_reg;
        out_valid_next = out_valid_reg && !res.ready;
        out_entry_next = out_entry_reg;
        out_pos_next   = out_pos_reg;
        out_last_next  = out_last_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                cur_next = cmd.front_entry[AW-1:0];
                if (accept && (cmd.op == OP_QUERY)
                    && ({1'b0, cmd.front_entry} < ENTRY_LIM))
                begin
                    steps_next = '0;
                    state_next = S_BACK;
                end
            end
            S_BACK:
            begin
                if (pred_rd_present)
                begin
                    cur_next   = pred_rd_data;
                    steps_next = steps_reg + 1'b1;
                    if (steps_reg == STEP_MAX)
                    begin
                        pos_next   = '0;
                        state_next = S_FWD;
                    end
                end
                else
                begin
                    pos_next   = '0;
                    state_next = S_FWD;
                end
            end
            S_FWD:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_entry_next = cur_reg;
                    out_pos_next   = pos_reg;
                    out_last_next  = tail;
                    if (tail)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cur_next = succ_rd_data;
                        pos_next = pos_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign rd_addr = cur_next;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            steps_reg     <= '0;
            pos_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            steps_reg     <= steps_next;
            pos_reg       <= pos_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cur_reg       <= cur_next;
        out_entry_reg <= out_entry_next;
        out_pos_reg   <= out_pos_next;
        out_last_reg  <= out_last_next;
    end

    assign res.valid          = out_valid_reg;
    assign res.entry_id       = ENTRY_W'(out_entry_reg);
    assign res.chain_position = ENTRY_W'(out_pos_reg);
    assign res.last           = out_last_reg;

endmodule

### sv/linked_chain_manager.sv
// ----------------------------------------------------------------------------
// linked_chain_manager
// Doubly linked entry set held in a predecessor and a successor table.
// ----------------------------------------------------------------------------
// connect and disconnect give no result
// a query walks back along the predecessor links until an entry has none or
// the step cap ends it, then walks forward emitting one item per entry; result
// stalls hold the walk, with one item in flight at a time; a new command is
// taken once the walk ends
// reset (async, rst_n low) marks every link absent and idles the walker
module linked_chain_manager #(
    parameter int NUM_ENTRIES = 64
) (
    input  logic      clk,
    input  logic      rst_n,
    lcm_cmd_if.sink   cmd,
    lcm_res_if.source res
);
    import lcm_pkg::*;

    localparam int AW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;

    link_cmd_t     pred_cmd, succ_cmd;
    logic [AW-1:0] pred_wr_addr, pred_wr_data;
    logic [AW-1:0] succ_wr_addr, succ_wr_data;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] pred_rd_data, succ_rd_data;
    logic          pred_rd_present, succ_rd_present;

    // sequencer and result register
    lcm_walker #(
        .NUM_ENTRIES (NUM_ENTRIES),
        .AW          (AW)
    ) u_walker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .res             (res),
        .pred_cmd        (pred_cmd),
        .succ_cmd        (succ_cmd),
        .pred_wr_addr    (pred_wr_addr),
        .pred_wr_data    (pred_wr_data),
        .succ_wr_addr    (succ_wr_addr),
        .succ_wr_data    (succ_wr_data),
        .rd_addr         (rd_addr),
        .pred_rd_data    (pred_rd_data),
        .pred_rd_present (pred_rd_present),
        .succ_rd_data    (succ_rd_data),
        .succ_rd_present (succ_rd_present)
    );

    // predecessor table
    lcm_link_ram #(
        .DEPTH (NUM_ENTRIES),
        .AW    (AW)
    ) u_pred_ram (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (pred_cmd),
        .wr_addr    (pred_wr_addr),
        .wr_data    (pred_wr_data),
        .rd_addr    (rd_addr),
        .rd_data    (pred_rd_data),
        .rd_present (pred_rd_present)
    );

    // successor table
    lcm_link_ram #(
        .DEPTH (NUM_ENTRIES),
        .AW    (AW)
    ) u_succ_ram (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (succ_cmd),
        .wr_addr    (succ_wr_addr),
        .wr_data    (succ_wr_data),
        .rd_addr    (rd_addr),
        .rd_data    (succ_rd_data),
        .rd_present (succ_rd_present)
    );

endmodule

### verif/linked_chain_manager_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// linked_chain_manager_test
// Self-checking bench for the linked chain manager. Commands go in over the
// command channel. A local copy of both link tables predicts each chain walk.
// Every result item is checked field by field against the oldest predicted
// item. A short directed table runs first, then a random mix that is mostly
// chain building and queries, with random idling on both sides.
// ----------------------------------------------------------------------------
module linked_chain_manager_test;
    import lcm_pkg::*;

    localparam int         NUM_ENTRIES  = 64;
    localparam logic [6:0] NO_LINK      = 7'h7F;
    localparam op_t        OP_UNUSED    = 2'd3;
    localparam int         NUM_ROWS     = 25;
    localparam int         RANDOM_ITEMS = 345;
    localparam int         HOLD_CYCLES  = 300;
    localparam int         STALL_LIMIT  = 3000;
    localparam int         DRAIN_CYCLES = 2 * NUM_ENTRIES + 16;

    // one emitted chain entry
    typedef struct packed {
        entry_t id;
        entry_t pos;
        logic   tail;
    } chain_item_t;

    // one row of the directed stimulus; typed rows carry their own result
    typedef struct packed {
        op_t    op;
        entry_t front_entry;
        entry_t back_entry;
        logic   typed;
        logic   typed_has_item;
        entry_t typed_id;
        entry_t typed_pos;
        logic   typed_tail;
    } stim_row_t;

    logic clk;
    logic rst_n;

    lcm_cmd_if cmd_ch ();
    lcm_res_if res_ch ();

    linked_chain_manager #(
        .NUM_ENTRIES(NUM_ENTRIES)
    ) DUT (
        .clk  (clk),
        .rst_n(rst_n),
        .cmd  (cmd_ch),
        .res  (res_ch)
    );

    // local copy of the link tables
    logic [6:0]  prev_link [NUM_ENTRIES];
    logic [6:0]  next_link [NUM_ENTRIES];
    chain_item_t chain_q [$];

    stim_row_t directed_rows [NUM_ROWS];

    int   error_count = 0;
    int   idle_cycles = 0;
    logic calm;
    int   hold_requests;
    int   hold_served = 0;
    int   hold_left = 0;

    // clock
    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // apply one accepted command to the local tables, queue its walk if keep_items
    function automatic void apply_command(op_t op, entry_t front_e, entry_t back_e,
                                          logic keep_items);
        logic [6:0] cur;
        logic [6:0] link;
        logic       tail;
        int         steps;
        int         pos;
        chain_item_t item;
        if (op == OP_CONNECT || op == OP_DISCONNECT)
        begin
            if (front_e < NUM_ENTRIES && back_e < NUM_ENTRIES)
            begin
                next_link[front_e] = (op == OP_CONNECT) ? {1'b0, back_e} : NO_LINK;
                prev_link[back_e]  = (op == OP_CONNECT) ? {1'b0, front_e} : NO_LINK;
            end
            return;
        end
        if (op != OP_QUERY || front_e >= NUM_ENTRIES)
            return;
        // walk back to the head, capped so a loop ends
        cur = {1'b0, front_e};
        for (steps = 0; steps < NUM_ENTRIES; steps++)
        begin
            link = prev_link[cur[5:0]];
            if (link >= NUM_ENTRIES)
                break;
            cur = link;
        end
        // walk forward emitting each entry
        for (pos = 0; pos < NUM_ENTRIES; pos++)
        begin
            link = next_link[cur[5:0]];
            tail = (link >= NUM_ENTRIES) || (pos + 1 == NUM_ENTRIES);
            item.id   = cur[5:0];
            item.pos  = entry_t'(pos);
            item.tail = tail;
            if (keep_items)
                chain_q = {chain_q, item};
            if (tail)
                break;
            cur = link;
        end
    endfunction

    // offer one command item and wait until it is taken
    task automatic send_command(op_t op, entry_t front_e, entry_t back_e, logic use_model);
        if (!calm)
        begin
            while ($urandom_range(0, 99) < 15)
            begin
                cmd_ch.valid <= 1'b0;
                @(posedge clk);
            end
        end
        cmd_ch.valid       <= 1'b1;
        cmd_ch.op          <= op;
        cmd_ch.front_entry <= front_e;
        cmd_ch.back_entry  <= back_e;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        apply_command(op, front_e, back_e, use_model);
    endtask

    // random entry, mostly from a small pool so chains get long
    function automatic entry_t pick_entry();
        if ($urandom_range(0, 99) < 60)
            return entry_t'($urandom_range(0, 15));
        return entry_t'($urandom_range(0, NUM_ENTRIES - 1));
    endfunction

    // result checker
    always @(posedge clk)
    begin
        chain_item_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (chain_q.size() == 0)
            begin
                $display("%0t unexpected result: entry_id %0d chain_position %0d last %0b",
                         $time, res_ch.entry_id, res_ch.chain_position, res_ch.last);
                error_count++;
            end
            else
            begin
                want = chain_q.pop_front();
                if (res_ch.entry_id !== want.id)
                begin
                    $display("%0t entry_id mismatch: expected %0d actual %0d",
                             $time, want.id, res_ch.entry_id);
                    error_count++;
                end
                if (res_ch.chain_position !== want.pos)
                begin
                    $display("%0t chain_position mismatch: expected %0d actual %0d",
                             $time, want.pos, res_ch.chain_position);
                    error_count++;
                end
                if (res_ch.last !== want.tail)
                begin
                    $display("%0t last mismatch: expected %0b actual %0b",
                             $time, want.tail, res_ch.last);
                    error_count++;
                end
            end
        end
    end

    // result side ready, with random stalls and long hold-offs on request
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            res_ch.ready <= 1'b0;
            hold_left = hold_left - 1;
        end
        else if (hold_requests != hold_served)
        begin
            res_ch.ready <= 1'b0;
            hold_left   = HOLD_CYCLES - 1;
            hold_served = hold_served + 1;
        end
        else if (calm)
            res_ch.ready <= 1'b1;
        else
            res_ch.ready <= ($urandom_range(0, 99) >= 15);
    end

    // watchdog on cycles with no item moving
    always @(posedge clk)
    begin
        if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("%0t watchdog: no item moved for %0d cycles, %0d results outstanding",
                     $time, idle_cycles, chain_q.size());
            $display("** linked_chain_manager: FAILED **");
            $finish;
        end
    end

    // stimulus
    initial
    begin
        int     r;
        int     sent;
        int     len;
        int     k;
        int     roll;
        logic   paused;
        entry_t a;
        entry_t b;
        entry_t members [$];
        chain_item_t item;

        paused             = 1'b0;
        rst_n              <= 1'b0;
        calm               <= 1'b0;
        hold_requests      <= 0;
        cmd_ch.valid       <= 1'b0;
        cmd_ch.op          <= OP_CONNECT;
        cmd_ch.front_entry <= '0;
        cmd_ch.back_entry  <= '0;
        for (r = 0; r < NUM_ENTRIES; r++)
        begin
            prev_link[r] = NO_LINK;
            next_link[r] = NO_LINK;
        end

        //                op             front b    typed has  id   pos  tail
        directed_rows = '{
            '{OP_QUERY,      6'd0,  6'd0,  1'b1, 1'b1, 6'd0,  6'd0, 1'b1}, // reset state
            '{OP_QUERY,      6'd63, 6'd63, 1'b1, 1'b1, 6'd63, 6'd0, 1'b1},
            '{OP_UNUSED,     6'd5,  6'd6,  1'b1, 1'b0, 6'd0,  6'd0, 1'b0}, // no effect
            '{OP_QUERY,      6'd5,  6'd0,  1'b1, 1'b1, 6'd5,  6'd0, 1'b1},
            '{OP_CONNECT,    6'd0,  6'd63, 1'b0, 1'b0, 6'd0,  6'd0, 1'b0},
            '{OP_QUERY,      6'd63, 6'd0,  1'b0, 1'b0, 6'd0,  6'd0, 1'b0},
            '{OP_DISCONNECT, 6'd0,  6'd63, 1'b0, 1'b0, 6'd0,  6'd0, 1'b0},
            '{OP_QUERY,      6'd0,  6'd63, 1'b1, 1'b1, 6'd0,  6'd0, 1'b1},
            '{OP_CONNECT,    6'd5,  6'd5,  1'b0, 1'b0, 6'd0,  6'd0, 1'b0}, // self link
            '{OP_QUERY,      6'd5,  6'd0,  1'b0, 1'b0, 6'd0,  6'd0, 1'b0},
            '{OP_CONNECT,    6'd10, 6'd11, 1'b0, 1'b0, 6'd0,  6'd0, 1'b0},
            '{OP_CONNECT,    6'd11, 6'd12, 1'b0, 1'b0, 6'd0,  6'd0, 1'b0},
            '{OP_CONNECT,    6'd12, 6'd13, 1'b0, 1'b0, 6'd0,  6'd0, 1'b0},
            '{OP_QUERY,      6'd12, 6'd0,  1'b0, 1'b0, 6'd0,  6'd0, 1'b0},
            '{OP_CONNECT,    6'd10, 6'd12, 1'b0, 1'b0, 6'd0,  6'd0, 1'b0}, // overwrite
            '{OP_QUERY,      6'd11, 6'd0,  1'b0, 1'b0, 6'd0,  6'd0, 1'b0},
            '{OP_CONNECT,    6'd20, 6'd21, 1'b0, 1'b0, 6'd0,  6'd0, 1'b0},
            '{OP_CONNECT,    6'd21, 6'd22, 1'b0, 1'b0, 6'd0,  6'd0, 1'b0},
            '{OP_CONNECT,    6'd22, 6'd20, 1'b0, 1'b0, 6'd0,  6'd0, 1'b0}, // loop
            '{OP_QUERY,      6'd21, 6'd0,  1'b0, 1'b0, 6'd0,  6'd0, 1'b0},
            '{OP_DISCONNECT, 6'd63, 6'd0,  1'b0, 1'b0, 6'd0,  6'd0, 1'b0},
            '{OP_CONNECT,    6'd63, 6'd0,  1'b0, 1'b0, 6'd0,  6'd0, 1'b0},
            '{OP_QUERY,      6'd0,  6'd0,  1'b0, 1'b0, 6'd0,  6'd0, 1'b0},
            '{OP_DISCONNECT, 6'd42, 6'd21, 1'b0, 1'b0, 6'd0,  6'd0, 1'b0}, // opens loop
            '{OP_QUERY,      6'd22, 6'd0,  1'b0, 1'b0, 6'd0,  6'd0, 1'b0}
        };

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part
        for (r = 0; r < NUM_ROWS; r++)
        begin
            send_command(directed_rows[r].op, directed_rows[r].front_entry,
                         directed_rows[r].back_entry, !directed_rows[r].typed);
            if (directed_rows[r].typed && directed_rows[r].typed_has_item)
            begin
                item.id   = directed_rows[r].typed_id;
                item.pos  = directed_rows[r].typed_pos;
                item.tail = directed_rows[r].typed_tail;
                chain_q = {chain_q, item};
            end
        end

        // long result hold-off while queries of the self loop keep coming
        hold_requests <= hold_requests + 1;
        for (k = 0; k < 4; k++)
            send_command(OP_QUERY, 6'd5, entry_t'($urandom_range(0, 63)), 1'b1);

        // random part
        sent = 4;
        while (sent < RANDOM_ITEMS)
        begin
            // sender pause until all results are in
            if (!paused && sent >= 180)
            begin
                while (chain_q.size() != 0)
                begin
                    cmd_ch.valid <= 1'b0;
                    @(posedge clk);
                end
                paused = 1'b1;
            end
            // stretch with no idling on either side
            calm <= (sent >= 230 && sent < 310);

            roll = $urandom_range(0, 99);
            if (roll < 45)
            begin
                // build a chain of random members, then query one of them
                len = $urandom_range(2, 14);
                members.delete();
                for (k = 0; k < len; k++)
                    members = {members, pick_entry()};
                for (k = 0; k + 1 < len; k++)
                    send_command(OP_CONNECT, members[k], members[k + 1], 1'b1);
                send_command(OP_QUERY, members[$urandom_range(0, len - 1)], pick_entry(), 1'b1);
                sent += len;
            end
            else
            begin
                a = pick_entry();
                b = pick_entry();
                if (roll < 65)
                    send_command(OP_CONNECT, a, b, 1'b1);
                else if (roll < 78)
                    send_command(OP_DISCONNECT, a, b, 1'b1);
                else if (roll < 96)
                    send_command(OP_QUERY, a, b, 1'b1);
                else
                    send_command(OP_UNUSED, a, b, 1'b1);
                sent++;
            end
        end

        // drain and let the walker settle
        cmd_ch.valid <= 1'b0;
        calm         <= 1'b0;
        while (chain_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("** linked_chain_manager: PASSED **");
        else
            $display("** linked_chain_manager: FAILED **");
        $finish;
    end

endmodule
